// ===== rtl/kwm_pkg.sv =====
package kwm_pkg;

  localparam int NUM_LISTS   = 8;
  localparam int LIST_DEPTH  = 256;
  localparam int VAL_W       = 32;
  localparam int LIST_W      = $clog2(NUM_LISTS);
  localparam int POS_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // command codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_DROPPED = 3'd1;
  localparam logic [2:0] ST_POPPED  = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [1:0]              op;
    logic [2:0]              list_index;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] merged_value;
    logic [2:0]              source_list;
  } result_t;

  // one head offered to the compare unit
  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [LIST_W-1:0] idx;
  } cand_t;

  // running minimum held by the compare unit
  typedef struct packed {
    logic                    found;
    logic [LIST_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
  } best_t;

  function automatic logic [ADDR_W-1:0] list_addr(logic [LIST_W-1:0] k, logic [POS_W-1:0] p);
    return ADDR_W'(k) * ADDR_W'(LIST_DEPTH) + ADDR_W'(p);
  endfunction

endpackage

// ===== rtl/kwm_store.sv =====
module kwm_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kwm_min_unit.sv =====
module kwm_min_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr,
  input  kwm_pkg::cand_t           cand,
  input  logic [kwm_pkg::VAL_W-1:0] cand_val,
  output kwm_pkg::best_t           best
);
  import kwm_pkg::*;

  logic take;

  // strict less-than keeps the lowest list on ties
  assign take = cand.vld && cand.ok &&
                (!best.found || ($signed(cand_val) < $signed(best.val)));

  always_ff @(posedge clk) begin
    if (rst) begin
      best.found <= 1'b0;
    end else if (clr) begin
      best.found <= 1'b0;
    end else if (take) begin
      best.found <= 1'b1;
      best.idx   <= cand.idx;
      best.val   <= cand_val;
    end
  end

endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// k-way sorted merge: up to NUM_LISTS lists of signed 32-bit values share one
// store of NUM_LISTS*LIST_DEPTH words. A command is taken when start is high and
// busy is low, and each command produces exactly one result, shown on result for
// a single cycle with result_valid high; the receiver cannot stall, so the
// result must be captured in that cycle. A load first registers the target list
// and value, then in S_LOAD looks up the fill count of that list and writes the
// word at its tail. A pop reads the heads one list per cycle through the single
// read port of the store and feeds them to one signed compare unit; then S_DRAIN
// lets the last compare finish, S_FINISH selects the winning list and S_ADVANCE
// advances its read position. Clear and the unused code are answered from S_IDLE.
// Lists are emptied by zeroing their fill counts, so no clearing pass over the
// store is needed and the block is ready right after reset. Ties go to the lowest list index.
module k_way_sorted_merge (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  kwm_pkg::cmd_t    cmd,
  output logic             result_valid,
  output kwm_pkg::result_t result
);
  import kwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_ADVANCE
  } state_t;

  localparam logic [LIST_W-1:0] LAST_LIST = LIST_W'(NUM_LISTS - 1);

  state_t            state;
  logic [CNT_W-1:0]  fill_count    [NUM_LISTS];
  logic [CNT_W-1:0]  read_position [NUM_LISTS];
  logic [LIST_W-1:0] cursor;
  logic              drop_req;
  logic [VAL_W-1:0]  load_value;
  cand_t             cand;
  best_t             best;

  logic              accept;
  logic              min_clr;
  logic [CNT_W-1:0]  cur_fill;
  logic [CNT_W-1:0]  cur_pos;
  logic              list_full;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign min_clr = accept && (cmd.op == OP_POP);

  // every access to the counters goes through the cursor, except reset and clear, which zero them all
  assign cur_fill  = fill_count[cursor];
  assign cur_pos   = read_position[cursor];
  assign list_full = (cur_fill == CNT_W'(LIST_DEPTH));

  // load writes at the tail, scan reads the head of the list under the cursor
  assign wr_en   = (state == S_LOAD) && !drop_req && !list_full;
  assign wr_addr = list_addr(cursor, cur_fill[POS_W-1:0]);
  assign rd_addr = list_addr(cursor, cur_pos[POS_W-1:0]);

  kwm_store #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (load_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // compare unit sees each head in the cycle after its read is issued
  kwm_min_unit u_min (
    .clk      (clk),
    .rst      (rst),
    .clr      (min_clr),
    .cand     (cand),
    .cand_val (rd_data),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      cand.vld     <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_count[i]    <= '0;
        read_position[i] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      cand.vld     <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.op)
              OP_LOAD: begin
                cursor     <= LIST_W'(cmd.list_index);
                drop_req   <= (int'(cmd.list_index) >= NUM_LISTS);
                load_value <= cmd.value;
                state      <= S_LOAD;
              end
              OP_POP: begin
                cursor <= '0;
                state  <= S_SCAN;
              end
              OP_CLEAR: begin
                for (int i = 0; i < NUM_LISTS; i++) begin
                  fill_count[i]    <= '0;
                  read_position[i] <= '0;
                end
                result       <= '{status: ST_CLEARED, merged_value: '0, source_list: '0};
                result_valid <= 1'b1;
              end
              default: begin
                // unused code: no state change
                result       <= '{status: ST_EMPTY, merged_value: '0, source_list: '0};
                result_valid <= 1'b1;
              end
            endcase
          end
        end
        S_LOAD: begin
          if (drop_req || list_full) begin
            result <= '{status: ST_DROPPED, merged_value: '0, source_list: '0};
          end else begin
            fill_count[cursor] <= cur_fill + 1'b1;
            result <= '{status: ST_LOADED, merged_value: '0, source_list: '0};
          end
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          // a list offers its head only while it has unread words
          cand.vld <= 1'b1;
          cand.ok  <= (cur_pos < cur_fill);
          cand.idx <= cursor;
          if (cursor == LAST_LIST) begin
            state <= S_DRAIN;
          end else begin
            cursor <= LIST_W'(cursor + 1'b1);
          end
        end
        S_DRAIN: begin
          // last head is compared at this edge
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (best.found) begin
            cursor <= best.idx;
            state  <= S_ADVANCE;
          end else begin
            result       <= '{status: ST_EMPTY, merged_value: '0, source_list: '0};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_ADVANCE: begin
          read_position[cursor] <= cur_pos + 1'b1;
          result       <= '{status: ST_POPPED, merged_value: best.val,
                            source_list: 3'(best.idx)};
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/kwm_checker.sv =====
module kwm_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input kwm_pkg::result_t result
);
  import kwm_pkg::*;

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("block not idle after reset");

  // an accepted transfer is either still at work or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || result_valid))
    else $error("accepted command neither busy nor answered");

  // results are only shown once the block is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // value and source are zero unless a pop succeeded
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_POPPED)) |->
      ((result.merged_value == '0) && (result.source_list == '0)))
    else $error("nonzero payload on non-pop result");

  // a result only follows a command transfer or ongoing work
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) || $past(start)))
    else $error("result without a command");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

// ===== tb/k_way_sorted_merge_tb.sv =====
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;
  import kwm_pkg::*;

  // the one code the package leaves unnamed: answers like a pop on drained lists
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // a pop is the slowest command and sender gaps are bounded by MAX_GAP,
  // so a quiet stretch this long means the block has hung
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4 * (NUM_LISTS + 4);
  localparam int MAX_GAP      = 16;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    result_valid;
  result_t result;

  k_way_sorted_merge u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predicted contents of the lists
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] list_words [NUM_LISTS][LIST_DEPTH];
  int                      list_fill  [NUM_LISTS];
  int                      list_head  [NUM_LISTS];

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      quiet_cycles   = 0;
  int      items_sent     = 0;
  int      sender_idle_pct = 0;

  // applies one command to the predicted lists and returns the result it earns
  function automatic result_t merge_predict(cmd_t c);
    result_t                 r;
    bit                      found;
    int                      best;
    logic signed [VAL_W-1:0] best_val;
    logic signed [VAL_W-1:0] head_val;
    r        = '0;
    found    = 1'b0;
    best     = 0;
    best_val = '0;
    case (c.op)
      OP_LOAD: begin
        // out-of-range index or a list that has taken its depth this job: dropped
        if (int'(c.list_index) >= NUM_LISTS || list_fill[c.list_index] >= LIST_DEPTH) begin
          r.status = ST_DROPPED;
        end else begin
          list_words[c.list_index][list_fill[c.list_index]] = c.value;
          list_fill[c.list_index]++;
          r.status = ST_LOADED;
        end
      end
      OP_POP: begin
        // scan upward with strict less-than so ties stay with the lowest list
        for (int k = 0; k < NUM_LISTS; k++) begin
          if (list_head[k] < list_fill[k]) begin
            head_val = list_words[k][list_head[k]];
            if (!found || head_val < best_val) begin
              found    = 1'b1;
              best     = k;
              best_val = head_val;
            end
          end
        end
        if (found) begin
          list_head[best]++;
          r.status       = ST_POPPED;
          r.merged_value = best_val;
          r.source_list  = 3'(best);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_CLEAR: begin
        // consumed slots come back only here
        for (int k = 0; k < NUM_LISTS; k++) begin
          list_fill[k] = 0;
          list_head[k] = 0;
        end
        r.status = ST_CLEARED;
      end
      default: begin
        r.status = ST_EMPTY;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predicts on every command transfer, checks every result strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (start && !busy) begin
        pending_results.insert(pending_results.size(), merge_predict(cmd));
      end
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", result.status, -1);
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
          if (result.merged_value !== want.merged_value)
            report_mismatch("merged_value", result.merged_value, want.merged_value);
          if (result.source_list !== want.source_list)
            report_mismatch("source_list", result.source_list, want.source_list);
        end
      end
      // quiet means no command transfer and no result in this cycle
      if ((start && !busy) || result_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("k_way_sorted_merge_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic cmd_t make_cmd(logic [1:0] op, int idx, logic [31:0] v);
    cmd_t c;
    c.op         = op;
    c.list_index = 3'(idx);
    c.value      = v;
    return c;
  endfunction

  // any command at all, fields fully random
  function automatic cmd_t random_cmd();
    return make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom);
  endfunction

  // one command transfer; a random gap may come first, with junk on cmd
  task automatic send_cmd(cmd_t c);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      cmd   <= random_cmd();
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, ties, unsorted heads, ignored fields and the unused code
  task automatic test_directed();
    send_cmd(make_cmd(OP_POP, 5, 32'hdead_beef));      // nothing loaded yet
    send_cmd(make_cmd(OP_UNUSED, 7, 32'hffff_ffff));
    send_cmd(make_cmd(OP_CLEAR, 3, 32'h1234_5678));
    send_cmd(make_cmd(OP_LOAD, 0, 32'h7fff_ffff));
    send_cmd(make_cmd(OP_LOAD, 7, 32'h8000_0000));
    send_cmd(make_cmd(OP_LOAD, 3, 32'h0000_0000));
    send_cmd(make_cmd(OP_LOAD, 5, 32'h0000_0000));      // ties with list 3
    send_cmd(make_cmd(OP_POP, 0, 32'h0));               // most negative, list 7
    send_cmd(make_cmd(OP_POP, 7, 32'hffff_ffff));       // tie goes to list 3
    send_cmd(make_cmd(OP_POP, 2, 32'h5555_5555));
    send_cmd(make_cmd(OP_POP, 0, 32'h0));               // most positive, list 0
    send_cmd(make_cmd(OP_POP, 0, 32'h0));               // all drained
    // unsorted list 2 against list 6
    send_cmd(make_cmd(OP_LOAD, 2, 32'haaaa_aaaa));
    send_cmd(make_cmd(OP_LOAD, 2, 32'h5555_5555));
    send_cmd(make_cmd(OP_LOAD, 6, 32'hffff_ffff));
    send_cmd(make_cmd(OP_LOAD, 1, 32'hffff_ffff));
    send_cmd(make_cmd(OP_POP, 0, 32'h0));
    send_cmd(make_cmd(OP_POP, 0, 32'h0));
    send_cmd(make_cmd(OP_POP, 0, 32'h0));
    send_cmd(make_cmd(OP_UNUSED, 0, 32'h0));            // no state change
    send_cmd(make_cmd(OP_POP, 0, 32'h0));
    send_cmd(make_cmd(OP_POP, 0, 32'h0));
    send_cmd(make_cmd(OP_LOAD, 4, 32'h0000_0001));
    send_cmd(make_cmd(OP_CLEAR, 0, 32'h0));             // load above is discarded
    send_cmd(make_cmd(OP_POP, 0, 32'h0));
  endtask

  // a list takes LIST_DEPTH loads per job; pops do not free slots
  task automatic test_list_full();
    send_cmd(make_cmd(OP_CLEAR, 0, 32'h0));
    for (int i = 0; i < LIST_DEPTH; i++)
      send_cmd(make_cmd(OP_LOAD, 4, 32'(i * 3 - 300)));
    send_cmd(make_cmd(OP_LOAD, 4, 32'h0));               // full: dropped
    send_cmd(make_cmd(OP_LOAD, 1, 32'hffff_ff00));
    repeat (4) send_cmd(make_cmd(OP_POP, 0, 32'h0));
    send_cmd(make_cmd(OP_LOAD, 4, 32'h7fff_ffff));       // still full after pops
    send_cmd(make_cmd(OP_CLEAR, 0, 32'h0));
    send_cmd(make_cmd(OP_LOAD, 4, 32'h8000_0000));       // accepted again
    send_cmd(make_cmd(OP_POP, 0, 32'h0));
  endtask

  // starting value of a list in a job: narrow jobs crowd values to force ties
  function automatic longint job_start_value(bit narrow);
    int pick;
    pick = $urandom_range(0, 7);
    if (narrow) return longint'($urandom_range(0, 8)) - 4;
    case (pick)
      0:       return -longint'(2147483647) - 1;
      1:       return longint'(2147483647) - longint'($urandom_range(0, 3));
      2:       return 0;
      default: return longint'($signed(32'($urandom)));
    endcase
  endfunction

  // one merge job: usually a clear, mostly sorted loads into random lists, then one pop more than there were loads;
  // some commands along the way are random noise
  task automatic run_merge_job();
    longint last_val [NUM_LISTS];
    bit     started  [NUM_LISTS];
    bit     narrow;
    int     n_loads;
    int     idx;
    longint v;
    narrow = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < NUM_LISTS; k++) started[k] = 1'b0;
    if ($urandom_range(0, 9) != 0) send_cmd(make_cmd(OP_CLEAR, $urandom_range(0, 7), $urandom));
    n_loads = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    for (int i = 0; i < n_loads; i++) begin
      if ($urandom_range(0, 19) == 0) send_cmd(random_cmd());
      idx = $urandom_range(0, NUM_LISTS - 1);
      if (!started[idx]) begin
        v = job_start_value(narrow);
        started[idx] = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        v = longint'($signed(32'($urandom)));           // breaks the order
      end else begin
        v = last_val[idx] + (narrow ? $urandom_range(0, 2) : $urandom_range(0, 1 << 20));
      end
      if (v > longint'(2147483647)) v = 2147483647;
      last_val[idx] = v;
      send_cmd(make_cmd(OP_LOAD, idx, 32'(v)));
    end
    for (int i = 0; i <= n_loads; i++) begin
      if ($urandom_range(0, 19) == 0) send_cmd(random_cmd());
      send_cmd(make_cmd(OP_POP, $urandom_range(0, 7), $urandom));
    end
  endtask

  task automatic test_random_merge(int n_items, int idle_pct);
    int stop_at;
    sender_idle_pct = idle_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) run_merge_job();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < NUM_LISTS; k++) begin
      list_fill[k] = 0;
      list_head[k] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 0;
    test_directed();
    sender_idle_pct = 6;
    test_list_full();
    test_random_merge(500, 0);
    test_random_merge(500, 82);
    test_random_merge(500, 6);
    test_random_merge(300, 0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("k_way_sorted_merge_tb: clean");
    end else begin
      $display("k_way_sorted_merge_tb: errors");
    end
    $finish;
  end

endmodule
